// ----- rtl/tag_whitelist_table_top_macros.svh -----
// Assertion macros shared by the table RTL.
`ifndef TAG_WHITELIST_TABLE_TOP_MACROS_SVH
`define TAG_WHITELIST_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define TWT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle
`define TWT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);
`else
`define TWT_ASSERT(label, prop, msg)
`define TWT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- rtl/twt_pkg.sv -----
package twt_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int ID_BYTES    = 10;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IDX_W       = 5;
    localparam int ID_W        = 80;
    localparam int ID_FIELD_BYTES = ID_W / 8;

    localparam logic [7:0] SRC_A = 8'hAA;
    localparam logic [7:0] SRC_B = 8'hCC;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LIST   = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        STS_ADDED     = 4'd0,
        STS_EXISTED   = 4'd1,
        STS_DELETED   = 4'd2,
        STS_FOUND     = 4'd3,
        STS_NOT_FOUND = 4'd4,
        STS_LISTED    = 4'd5,
        STS_EMPTY     = 4'd6,
        STS_FULL      = 4'd7,
        STS_REJECTED  = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_DEL,
        ST_LIST_RD,
        ST_LIST_CAP,
        ST_EMIT
    } state_t;

    // One table record as held in the memory
    typedef struct packed {
        logic [7:0]  level;
        logic [7:0]  kind;
        logic [3:0]  length;
        logic [15:0] id_high;
        logic [63:0] id_low;
    } rec_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] pos;
        rec_t             rec;
        logic             last;
    } res_t;

    // Byte mask over the id for a given length, clamped to ID_BYTES
    function automatic logic [ID_W-1:0] key_mask(input logic [3:0] len);
        logic [ID_W-1:0] m;
        m = '0;
        for (int b = 0; b < ID_FIELD_BYTES; b++) begin
            if (b < int'(len) && b < ID_BYTES) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/twt_store.sv -----
module twt_store
    import twt_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  rec_t              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output rec_t              rd_data
);

    rec_t mem [MAX_ENTRIES];
    rec_t rd_data_reg;

    // Write one record
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one record, hold the data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tag_whitelist_table_top.sv -----
// Insert and lookup: the search reads and compares one entry per cycle from the table start;
// a hit ends the search early, and a full result comes after the whole search.
// Delete: later entries move down one per cycle.
// List: each entry passes through the read, capture and emit states in turn.
// Rejected and empty results go from accept to the emit state, then to the output register.
// One request at a time; reset clears the entry count and control, not the table memory.
`include "tag_whitelist_table_top_macros.svh"

module tag_whitelist_table_top
    import twt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // source[7:0], entry_index[12:8], id_low[76:13], id_high[92:77],
    // key_length[96:93], card_kind[104:97], access_level[112:105], zero[119:113]
    input  logic [119:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // position[5:0], entry_count[11:6], out_id_low[75:12], out_id_high[91:76],
    // out_length[95:92], out_kind[103:96], out_level[111:104]
    output logic [111:0] m_tdata,
    // status[3:0]
    output logic [3:0]   m_tuser,
    output logic         m_tlast
);

    // Unpack the input word
    logic [7:0]       in_src;
    logic [IDX_W-1:0] in_idx;
    logic [63:0]      in_idl;
    logic [15:0]      in_idh;
    logic [3:0]       in_len;
    logic [7:0]       in_kind;
    logic [7:0]       in_lvl;
    req_t             in_req;
    logic             src_ok;

    assign in_src  = s_tdata[7:0];
    assign in_idx  = s_tdata[12:8];
    assign in_idl  = s_tdata[76:13];
    assign in_idh  = s_tdata[92:77];
    assign in_len  = s_tdata[96:93];
    assign in_kind = s_tdata[104:97];
    assign in_lvl  = s_tdata[112:105];
    assign in_req  = req_t'(s_tuser);
    assign src_ok  = (in_src == SRC_A) || (in_src == SRC_B);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic             m_valid_reg, m_valid_next;
    res_t             res_reg, res_next;
    res_t             out_reg, out_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    // Latched request
    req_t             req_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [63:0]      idl_reg;
    logic [15:0]      idh_reg;
    logic [3:0]       len_reg;
    logic [7:0]       kind_reg;
    logic [7:0]       lvl_reg;
    logic             req_load;

    // Memory port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    rec_t              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    rec_t              rd_data;

    logic [ID_W-1:0] mask;
    rec_t            new_rec;
    rec_t            echo_rec;
    logic            match;
    logic [CNT_W-1:0] idx_ext;

    twt_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Build the masked key and the compare against the word just read
    assign mask = key_mask(len_reg);
    assign new_rec.id_low  = idl_reg & mask[63:0];
    assign new_rec.id_high = idh_reg & mask[79:64];
    assign new_rec.length  = len_reg;
    assign new_rec.kind    = kind_reg;
    assign new_rec.level   = lvl_reg;

    assign echo_rec.id_low  = idl_reg;
    assign echo_rec.id_high = idh_reg;
    assign echo_rec.length  = len_reg;
    assign echo_rec.kind    = kind_reg;
    assign echo_rec.level   = lvl_reg;

    assign match = (rd_data.id_low == new_rec.id_low) && (rd_data.id_high == new_rec.id_high)
                && (rd_data.length == len_reg) && (rd_data.kind == kind_reg);

    assign idx_ext = CNT_W'(idx_reg);

    // Next state, memory access and result building
    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_valid_next   = 1'b0;
        held_count_next = held_count_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_count_next  = out_count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        req_load        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = held_count_reg[ADDR_W-1:0];
        wr_data         = new_rec;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_load      = 1'b1;
                    ptr_next      = '0;
                    res_next.status = STS_REJECTED;
                    res_next.pos    = '0;
                    res_next.rec    = '0;
                    res_next.last   = 1'b1;
                    state_next      = ST_EMIT;
                    unique case (in_req)
                        REQ_INSERT: begin
                            if (src_ok && in_len != 4'd0 && in_kind != 8'd0 && in_lvl != 8'd0
                                && int'(in_len) <= ID_BYTES) begin
                                state_next = ST_SRCH;
                            end
                        end
                        REQ_DELETE: begin
                            if (src_ok && int'(in_idx) < int'(held_count_reg)) begin
                                ptr_next   = CNT_W'(in_idx);
                                state_next = ST_DEL;
                            end
                        end
                        REQ_LIST: begin
                            if (src_ok) begin
                                if (held_count_reg == '0) begin
                                    res_next.status = STS_EMPTY;
                                end else begin
                                    state_next = ST_LIST_RD;
                                end
                            end
                        end
                        REQ_LOOKUP: begin
                            state_next = ST_SRCH;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SRCH: begin
                if (rd_valid_reg && match) begin
                    // Hit: report the stored record
                    res_next.status = (req_reg == REQ_INSERT) ? STS_EXISTED : STS_FOUND;
                    res_next.pos    = rd_ptr_reg;
                    res_next.rec    = rd_data;
                    res_next.last   = 1'b1;
                    state_next      = ST_EMIT;
                end else if (ptr_reg < held_count_reg) begin
                    // Advance the scan
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_ptr_next   = ptr_reg;
                    ptr_next      = ptr_reg + 1'b1;
                end else if (!rd_valid_reg) begin
                    // Miss on every entry
                    res_next.last = 1'b1;
                    state_next    = ST_EMIT;
                    if (req_reg == REQ_INSERT) begin
                        if (int'(held_count_reg) >= MAX_ENTRIES) begin
                            res_next.status = STS_FULL;
                            res_next.pos    = CNT_W'(MAX_ENTRIES);
                            res_next.rec    = '0;
                        end else begin
                            wr_en           = 1'b1;
                            res_next.status = STS_ADDED;
                            res_next.pos    = held_count_reg;
                            res_next.rec    = new_rec;
                            held_count_next = held_count_reg + 1'b1;
                        end
                    end else begin
                        res_next.status = STS_NOT_FOUND;
                        res_next.pos    = CNT_W'(MAX_ENTRIES);
                        res_next.rec    = echo_rec;
                    end
                end
            end

            ST_DEL: begin
                // Keep the removed record, move later ones down
                if (rd_valid_reg) begin
                    if (rd_ptr_reg == idx_ext) begin
                        res_next.rec = rd_data;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(rd_ptr_reg - 1'b1);
                        wr_data = rd_data;
                    end
                end
                if (ptr_reg < held_count_reg) begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_ptr_next   = ptr_reg;
                    ptr_next      = ptr_reg + 1'b1;
                end else if (!rd_valid_reg) begin
                    held_count_next = held_count_reg - 1'b1;
                    res_next.status = STS_DELETED;
                    res_next.pos    = idx_ext;
                    res_next.last   = 1'b1;
                    state_next      = ST_EMIT;
                end
            end

            ST_LIST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_LIST_CAP;
            end

            ST_LIST_CAP: begin
                res_next.status = STS_LISTED;
                res_next.pos    = ptr_reg;
                res_next.rec    = rd_data;
                res_next.last   = (ptr_reg + 1'b1) == held_count_reg;
                ptr_next        = ptr_reg + 1'b1;
                state_next      = ST_EMIT;
            end

            ST_EMIT: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    out_next       = res_reg;
                    out_count_next = held_count_reg;
                    m_valid_next   = 1'b1;
                    if (res_reg.status == STS_LISTED && !res_reg.last) begin
                        state_next = ST_LIST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            rd_valid_reg   <= rd_valid_next;
            held_count_reg <= held_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_ptr_reg    <= rd_ptr_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        out_count_reg <= out_count_next;
        if (req_load) begin
            req_reg  <= in_req;
            idx_reg  <= in_idx;
            idl_reg  <= in_idl;
            idh_reg  <= in_idh;
            len_reg  <= in_len;
            kind_reg <= in_kind;
            lvl_reg  <= in_lvl;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.rec.level, out_reg.rec.kind, out_reg.rec.length,
                       out_reg.rec.id_high, out_reg.rec.id_low,
                       6'(out_count_reg), 6'(out_reg.pos)};

    `TWT_ASSERT(a_count_bound, int'(held_count_reg) <= MAX_ENTRIES,
        "entry count above table size")
    `TWT_ASSERT(a_write_state, !wr_en || state_reg == ST_SRCH || state_reg == ST_DEL,
        "table written outside search or delete")
    `TWT_ASSERT(a_read_track, !rd_valid_reg || state_reg == ST_SRCH || state_reg == ST_DEL,
        "read data pending in wrong state")
    `TWT_ASSERT_NEXT(a_del_count, state_reg == ST_DEL && state_next == ST_EMIT,
        int'(held_count_reg) + 1 == int'($past(held_count_reg)),
        "delete did not drop one entry")
    `TWT_ASSERT(a_list_last,
        !(m_tvalid && m_tready && m_tuser == STS_LISTED && m_tlast)
            || int'(m_tdata[5:0]) + 1 == int'(m_tdata[11:6]),
        "last listed entry not at table end")

endmodule

// ----- bench/tb_tag_whitelist_table_top.sv -----
`timescale 1ns / 100ps

module tb_tag_whitelist_table_top;
    import twt_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int POOL_KEYS   = 40;

    // One card request as carried by the input channel
    typedef struct {
        req_t        req;
        logic [7:0]  source;
        logic [4:0]  slot;
        logic [63:0] id_lo;
        logic [15:0] id_hi;
        logic [3:0]  id_len;
        logic [7:0]  kind;
        logic [7:0]  level;
    } card_req_t;

    // One table report as carried by the result channel
    typedef struct packed {
        status_t     status;
        logic [5:0]  pos;
        logic [5:0]  count;
        logic [63:0] id_lo;
        logic [15:0] id_hi;
        logic [3:0]  id_len;
        logic [7:0]  kind;
        logic [7:0]  level;
        logic        last;
    } card_res_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    // Expected card reports, oldest first
    card_res_t pending_results[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // Shadow copy of the whitelist table
    logic [63:0] tbl_lo[MAX_ENTRIES];
    logic [15:0] tbl_hi[MAX_ENTRIES];
    logic [3:0]  tbl_len[MAX_ENTRIES];
    logic [7:0]  tbl_kind[MAX_ENTRIES];
    logic [7:0]  tbl_level[MAX_ENTRIES];
    int          held_n = 0;

    // Card keys reused by the random traffic so that hits and duplicates occur
    logic [63:0] pool_lo[POOL_KEYS];
    logic [15:0] pool_hi[POOL_KEYS];
    logic [3:0]  pool_len[POOL_KEYS];
    logic [7:0]  pool_kind[POOL_KEYS];

    tag_whitelist_table_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Valid id bytes of a key: bytes below min(length, ID_BYTES)
    function automatic logic [63:0] lo_byte_mask(input logic [3:0] len);
        int n;
        n = (int'(len) < ID_BYTES) ? int'(len) : ID_BYTES;
        return (n >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic logic [15:0] hi_byte_mask(input logic [3:0] len);
        int n;
        n = (int'(len) < ID_BYTES) ? int'(len) : ID_BYTES;
        return (n > 8) ? 16'((32'd1 << (8 * (n - 8))) - 32'd1) : 16'd0;
    endfunction

    function automatic void push_result(input status_t st, input int pos,
                                        input logic [63:0] lo, input logic [15:0] hi,
                                        input logic [3:0] len, input logic [7:0] kind,
                                        input logic [7:0] level, input logic last);
        card_res_t r;
        r.status = st;
        r.pos    = 6'(pos);
        r.count  = 6'(held_n);
        r.id_lo  = lo;
        r.id_hi  = hi;
        r.id_len = len;
        r.kind   = kind;
        r.level  = level;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void push_entry(input status_t st, input int i, input logic last);
        push_result(st, i, tbl_lo[i], tbl_hi[i], tbl_len[i], tbl_kind[i], tbl_level[i], last);
    endfunction

    // Apply one request to the shadow table and queue the reports it causes
    function automatic void predict_table_op(input card_req_t r);
        logic [63:0] klo;
        logic [15:0] khi;
        logic [63:0] gone_lo;
        logic [15:0] gone_hi;
        logic [3:0]  gone_len;
        logic [7:0]  gone_kind;
        logic [7:0]  gone_level;
        int          hit;
        bit          src_ok;
        src_ok = (r.source == SRC_A) || (r.source == SRC_B);
        klo    = r.id_lo & lo_byte_mask(r.id_len);
        khi    = r.id_hi & hi_byte_mask(r.id_len);
        // linear search, first match wins
        hit = MAX_ENTRIES;
        for (int i = 0; i < held_n; i++) begin
            if (hit == MAX_ENTRIES && tbl_lo[i] == klo && tbl_hi[i] == khi &&
                tbl_len[i] == r.id_len && tbl_kind[i] == r.kind) begin
                hit = i;
            end
        end
        case (r.req)
            REQ_INSERT: begin
                if (!src_ok || r.id_len == 0 || r.kind == 0 || r.level == 0 ||
                    int'(r.id_len) > ID_BYTES) begin
                    push_result(STS_REJECTED, 0, '0, '0, '0, '0, '0, 1'b1);
                end else if (hit < MAX_ENTRIES) begin
                    push_entry(STS_EXISTED, hit, 1'b1);
                end else if (held_n >= MAX_ENTRIES) begin
                    push_result(STS_FULL, MAX_ENTRIES, '0, '0, '0, '0, '0, 1'b1);
                end else begin
                    tbl_lo[held_n]    = klo;
                    tbl_hi[held_n]    = khi;
                    tbl_len[held_n]   = r.id_len;
                    tbl_kind[held_n]  = r.kind;
                    tbl_level[held_n] = r.level;
                    held_n++;
                    push_entry(STS_ADDED, held_n - 1, 1'b1);
                end
            end
            REQ_DELETE: begin
                if (!src_ok || int'(r.slot) >= held_n) begin
                    push_result(STS_REJECTED, 0, '0, '0, '0, '0, '0, 1'b1);
                end else begin
                    gone_lo    = tbl_lo[r.slot];
                    gone_hi    = tbl_hi[r.slot];
                    gone_len   = tbl_len[r.slot];
                    gone_kind  = tbl_kind[r.slot];
                    gone_level = tbl_level[r.slot];
                    // close the gap: later entries move down one place
                    for (int i = int'(r.slot); i + 1 < held_n; i++) begin
                        tbl_lo[i]    = tbl_lo[i + 1];
                        tbl_hi[i]    = tbl_hi[i + 1];
                        tbl_len[i]   = tbl_len[i + 1];
                        tbl_kind[i]  = tbl_kind[i + 1];
                        tbl_level[i] = tbl_level[i + 1];
                    end
                    held_n--;
                    push_result(STS_DELETED, int'(r.slot), gone_lo, gone_hi, gone_len,
                                gone_kind, gone_level, 1'b1);
                end
            end
            REQ_LIST: begin
                if (!src_ok) begin
                    push_result(STS_REJECTED, 0, '0, '0, '0, '0, '0, 1'b1);
                end else if (held_n == 0) begin
                    push_result(STS_EMPTY, 0, '0, '0, '0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < held_n; i++) begin
                        push_entry(STS_LISTED, i, i + 1 == held_n);
                    end
                end
            end
            default: begin
                if (hit < MAX_ENTRIES) begin
                    push_entry(STS_FOUND, hit, 1'b1);
                end else begin
                    push_result(STS_NOT_FOUND, MAX_ENTRIES, r.id_lo, r.id_hi, r.id_len,
                                r.kind, r.level, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic string fmt_res(input card_res_t r);
        return $sformatf("st=%0d pos=%0d cnt=%0d id=%h_%h len=%0d kind=%h lvl=%h last=%b",
                         r.status, r.pos, r.count, r.id_hi, r.id_lo, r.id_len, r.kind,
                         r.level, r.last);
    endfunction

    // Drive one request word and wait for its handshake; valid stays high afterwards
    task automatic send_word(input req_t req, input logic [7:0] src, input logic [4:0] slot,
                             input logic [63:0] lo, input logic [15:0] hi,
                             input logic [3:0] len, input logic [7:0] kind,
                             input logic [7:0] level);
        card_req_t w;
        int        gap;
        w.req    = req;
        w.source = src;
        w.slot   = slot;
        w.id_lo  = lo;
        w.id_hi  = hi;
        w.id_len = len;
        w.kind   = kind;
        w.level  = level;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, level, kind, len, hi, lo, slot, src};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_table_op(w);
    endtask

    // Hold the input channel quiet until every queued report has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    function automatic logic [7:0] good_source();
        return $urandom_range(1) ? SRC_A : SRC_B;
    endfunction

    // Requests on an empty table, list with a foreign source
    task automatic test_empty_table();
        send_word(REQ_LIST, SRC_A, 5'd0, '0, '0, 4'd1, 8'd1, 8'd1);
        send_word(REQ_LIST, 8'h00, 5'd0, '0, '0, 4'd1, 8'd1, 8'd1);
        send_word(REQ_DELETE, SRC_B, 5'd0, '0, '0, 4'd0, 8'd0, 8'd0);
        send_word(REQ_LOOKUP, 8'hFF, 5'd31, '1, '1, 4'd15, 8'hFF, 8'hFF);
    endtask

    // Insert rejection rules, then adds and a duplicate key
    task automatic test_insert_checks();
        send_word(REQ_INSERT, 8'h00, 5'd0, '1, '1, 4'd4, 8'd7, 8'd9);
        send_word(REQ_INSERT, 8'h55, 5'd0, '1, '1, 4'd4, 8'd7, 8'd9);
        send_word(REQ_INSERT, SRC_A, 5'd0, '1, '1, 4'd0, 8'd7, 8'd9);
        send_word(REQ_INSERT, SRC_A, 5'd0, '1, '1, 4'd4, 8'd0, 8'd9);
        send_word(REQ_INSERT, SRC_B, 5'd0, '1, '1, 4'd4, 8'd7, 8'd0);
        send_word(REQ_INSERT, SRC_B, 5'd0, '1, '1, 4'd11, 8'd7, 8'd9);
        // widest key, top kind and level
        send_word(REQ_INSERT, SRC_B, 5'd0, '1, '1, 4'd10, 8'hFF, 8'hFF);
        // one-byte key; bytes past the length are junk and must be dropped
        send_word(REQ_INSERT, SRC_A, 5'd0, 64'hDEAD_BEEF_CAFE_F00D, 16'h1234, 4'd1, 8'd1, 8'd1);
        send_word(REQ_INSERT, SRC_A, 5'd0, 64'h0123_4567_89AB_CD0D, 16'h0000, 4'd1, 8'd1, 8'h55);
        send_word(REQ_INSERT, SRC_B, 5'd0, 64'h0000_0000_0000_000D, 16'hFFFF, 4'd1, 8'd2, 8'hAA);
        send_word(REQ_INSERT, SRC_A, 5'd0, 64'h5555_5555_5555_AA0D, 16'h5555, 4'd2, 8'd1, 8'h80);
    endtask

    task automatic test_lookup();
        send_word(REQ_LOOKUP, 8'h00, 5'd0, '1, '1, 4'd10, 8'hFF, 8'h00);
        send_word(REQ_LOOKUP, 8'h12, 5'd0, 64'hAAAA_AAAA_AAAA_AA0D, 16'hAAAA, 4'd1, 8'd2, 8'd0);
        send_word(REQ_LOOKUP, SRC_A, 5'd0, 64'hAAAA_AAAA_AAAA_AA0D, 16'hAAAA, 4'd1, 8'd3, 8'd7);
    endtask

    // Delete rules and shift-down of later entries
    task automatic test_delete_shift();
        send_word(REQ_LIST, SRC_B, 5'd0, '0, '0, 4'd0, 8'd0, 8'd0);
        send_word(REQ_DELETE, 8'hAB, 5'd1, '0, '0, 4'd0, 8'd0, 8'd0);
        send_word(REQ_DELETE, SRC_A, 5'd31, '0, '0, 4'd0, 8'd0, 8'd0);
        send_word(REQ_DELETE, SRC_A, 5'd0, '0, '0, 4'd0, 8'd0, 8'd0);
        send_word(REQ_DELETE, SRC_B, 5'(held_n - 1), '0, '0, 4'd0, 8'd0, 8'd0);
        send_word(REQ_LIST, SRC_A, 5'd0, '0, '0, 4'd0, 8'd0, 8'd0);
    endtask

    // Fill to capacity, hit the full case, list everything, then empty the table
    task automatic test_fill_and_empty();
        int k;
        int guard;
        guard = 0;
        while (held_n < MAX_ENTRIES && guard < 200) begin
            send_word(REQ_INSERT, good_source(), 5'($urandom), {$urandom, $urandom},
                      16'($urandom), 4'($urandom_range(1, 10)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(1, 255)));
            guard++;
        end
        send_word(REQ_INSERT, good_source(), 5'd0, {$urandom, $urandom}, 16'($urandom),
                  4'd10, 8'($urandom_range(1, 255)), 8'd1);
        k = $urandom_range(held_n - 1);
        send_word(REQ_INSERT, good_source(), 5'd0,
                  tbl_lo[k] | ({$urandom, $urandom} & ~lo_byte_mask(tbl_len[k])),
                  tbl_hi[k], tbl_len[k], tbl_kind[k], 8'($urandom_range(1, 255)));
        k = $urandom_range(held_n - 1);
        send_word(REQ_LOOKUP, 8'($urandom), 5'($urandom), tbl_lo[k], tbl_hi[k], tbl_len[k],
                  tbl_kind[k], 8'($urandom));
        send_word(REQ_LIST, good_source(), 5'd0, '0, '0, 4'd0, 8'd0, 8'd0);
        guard = 0;
        while (held_n > 0 && guard < 100) begin
            send_word(REQ_DELETE, good_source(), 5'($urandom_range(held_n - 1)),
                      {$urandom, $urandom}, 16'($urandom), 4'($urandom), 8'($urandom),
                      8'($urandom));
            guard++;
        end
        send_word(REQ_LIST, good_source(), 5'd0, '0, '0, 4'd0, 8'd0, 8'd0);
    endtask

    // Mostly well-formed traffic on pooled keys, with some raw noise
    task automatic test_random_mix(input int items);
        int          pick;
        int          k;
        logic [63:0] junk_lo;
        logic [15:0] junk_hi;
        logic [63:0] klo;
        logic [15:0] khi;
        for (int n = 0; n < items; n++) begin
            pick    = $urandom_range(99);
            k       = $urandom_range(POOL_KEYS - 1);
            junk_lo = {$urandom, $urandom};
            junk_hi = 16'($urandom);
            klo = (pool_lo[k] & lo_byte_mask(pool_len[k])) |
                  (junk_lo & ~lo_byte_mask(pool_len[k]));
            khi = (pool_hi[k] & hi_byte_mask(pool_len[k])) |
                  (junk_hi & ~hi_byte_mask(pool_len[k]));
            if (pick < 40) begin
                send_word(REQ_INSERT, good_source(), 5'($urandom), klo, khi, pool_len[k],
                          pool_kind[k], 8'($urandom_range(1, 255)));
            end else if (pick < 55) begin
                send_word(REQ_DELETE, good_source(),
                          (held_n > 0) ? 5'($urandom_range(held_n - 1)) : 5'($urandom),
                          junk_lo, junk_hi, 4'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 62) begin
                send_word(REQ_LIST, good_source(), 5'($urandom), junk_lo, junk_hi,
                          4'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 85) begin
                send_word(REQ_LOOKUP, 8'($urandom), 5'($urandom), klo, khi, pool_len[k],
                          pool_kind[k], 8'($urandom));
            end else begin
                send_word(req_t'($urandom_range(3)), 8'($urandom), 5'($urandom), junk_lo,
                          junk_hi, 4'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Result channel backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result word with the oldest expected report
    always @(posedge aclk) begin : check_result
        card_res_t got;
        card_res_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.status = status_t'(m_tuser);
            got.pos    = m_tdata[5:0];
            got.count  = m_tdata[11:6];
            got.id_lo  = m_tdata[75:12];
            got.id_hi  = m_tdata[91:76];
            got.id_len = m_tdata[95:92];
            got.kind   = m_tdata[103:96];
            got.level  = m_tdata[111:104];
            got.last   = m_tlast;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word: %s", fmt_res(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", fmt_res(want));
                        $display("  actual   %s", fmt_res(got));
                    end
                end
            end
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < POOL_KEYS; k++) begin
            pool_lo[k]   = {$urandom, $urandom};
            pool_hi[k]   = 16'($urandom);
            pool_len[k]  = 4'($urandom_range(1, 10));
            pool_kind[k] = 8'($urandom_range(1, 255));
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        set_idling(0, 0);
        test_empty_table();
        test_insert_checks();
        test_lookup();
        test_delete_shift();
        wait_all_results();

        set_idling(29, 29);
        test_fill_and_empty();
        wait_all_results();

        set_idling(0, 0);
        test_random_mix(64);
        wait_all_results();
        set_idling(73, 0);
        test_random_mix(64);
        wait_all_results();
        set_idling(0, 73);
        test_random_mix(64);
        wait_all_results();
        set_idling(29, 29);
        test_random_mix(64);
        wait_all_results();

        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
